@@ rtl/core/lcr_pkg.sv @@
// types, constants and helpers shared by the line clip rectangle design
`default_nettype none
package lcr_pkg;

	localparam int COORD_BITS    = 12;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ADDR_BITS     = 4;
	localparam int DATA_BITS     = 32;
	localparam int NUM_EDGES     = 4;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0]   delta_t;
	typedef logic        [COORD_BITS-1:0] mag_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} seg_t;

	typedef struct packed {
		logic   visible;
		coord_t clipped_start_x;
		coord_t clipped_start_y;
		coord_t clipped_end_x;
		coord_t clipped_end_y;
	} clip_t;

	// start point and direction carried along the pipeline
	typedef struct packed {
		coord_t sx;
		coord_t sy;
		delta_t dx;
		delta_t dy;
	} geo_t;

	// per-edge sign flags
	typedef struct packed {
		logic pzero;
		logic pneg;
		logic qneg;
		logic neg;
	} lane_t;

	typedef enum logic [1:0] {
		REG_LEFT   = 2'd0,
		REG_BOTTOM = 2'd1,
		REG_RIGHT  = 2'd2,
		REG_TOP    = 2'd3
	} reg_idx_t;

	localparam coord_t WIN_LEFT_RST   = coord_t'(0);
	localparam coord_t WIN_BOTTOM_RST = coord_t'(0);
	localparam coord_t WIN_RIGHT_RST  = coord_t'(639);
	localparam coord_t WIN_TOP_RST    = coord_t'(479);

	function automatic mag_t abs_mag(input delta_t v);
		delta_t n;
		n = -v;
		return v[COORD_BITS] ? n[COORD_BITS-1:0] : v[COORD_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/line_clip_rectangle_top.sv @@
// line segment clipping against a rectangular window, pipelined
//
//  channel   dir  handshake                 payload
//  seg       in   seg_valid / seg_ready     seg_t  (start and end point)
//  clip      out  clip_valid / clip_ready   clip_t (visible flag, clipped points)
//  apb       in   psel/penable/pwrite/pready window registers
//
// one segment per cycle while the output is not stalled; one stage per quotient bit
// of the four rounded divisions, plus setup, operands, reduce, multiply and rounding
// arst_n clears all valid bits and loads the default 640x480 window
// each stage holds when the next one is full and stalled, so bubbles close up
// and nothing is dropped or repeated
`default_nettype none
module line_clip_rectangle_top #(
	parameter int FRAC_BITS = lcr_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              seg_valid,
	output logic                                   seg_ready,
	input  wire lcr_pkg::seg_t                     seg,
	output logic                                   clip_valid,
	input  wire logic                              clip_ready,
	output lcr_pkg::clip_t                         clip,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lcr_pkg::ADDR_BITS-1:0]     paddr,
	input  wire logic [lcr_pkg::DATA_BITS-1:0]     pwdata,
	output logic      [lcr_pkg::DATA_BITS-1:0]     prdata,
	output logic                                   pready
);
	import lcr_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int NW   = C + FRAC_BITS + 2;
	localparam int QW   = FRAC_BITS + 1;
	localparam int TW   = FRAC_BITS + 3;
	localparam int PW   = C + FRAC_BITS + 3;
	localparam int NS   = FRAC_BITS + 6;
	localparam int LAST = NS - 1;
	localparam int ST3  = FRAC_BITS + 3;
	localparam int ST4  = FRAC_BITS + 4;
	localparam logic signed [TW-1:0] U_ONE   = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic        [QW:0]   T_SAT   = {1'b1, {(FRAC_BITS-1){1'b0}}, 1'b1};
	localparam logic        [PW-1:0] HALF    = {{(PW-FRAC_BITS){1'b0}}, 1'b1,
		{(FRAC_BITS-1){1'b0}}};

	// window registers
	coord_t left_q, bottom_q, right_q, top_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= WIN_LEFT_RST;
			bottom_q <= WIN_BOTTOM_RST;
			right_q  <= WIN_RIGHT_RST;
			top_q    <= WIN_TOP_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_LEFT:   left_q   <= pwdata[C-1:0];
				REG_BOTTOM: bottom_q <= pwdata[C-1:0];
				REG_RIGHT:  right_q  <= pwdata[C-1:0];
				REG_TOP:    top_q    <= pwdata[C-1:0];
				default:    left_q   <= left_q;
			endcase
		end
	end

	always_comb begin
		coord_t rd;
		unique case (reg_idx_t'(paddr[3:2]))
			REG_LEFT:   rd = left_q;
			REG_BOTTOM: rd = bottom_q;
			REG_RIGHT:  rd = right_q;
			REG_TOP:    rd = top_q;
			default:    rd = left_q;
		endcase
		prdata = {{(DATA_BITS-C){rd[C-1]}}, rd};
	end

	// stage flow control
	logic [NS-1:0] vld;
	logic [NS-1:0] en;

	always_comb begin
		en[LAST] = !vld[LAST] || clip_ready;
		for (int i = LAST - 1; i >= 0; i--) begin
			en[i] = !vld[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[0]) begin
				vld[0] <= seg_valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					vld[i] <= vld[i-1];
				end
			end
		end
	end

	assign seg_ready  = en[0];
	assign clip_valid = vld[LAST];

	// stage 1: direction and distance terms per edge
	geo_t  geo_s1;
	lane_t lane_s1 [NUM_EDGES];
	mag_t  nm_s1   [NUM_EDGES];
	mag_t  dm_s1   [NUM_EDGES];

	always_ff @(posedge clk) begin
		delta_t sx, sy, dx, dy;
		delta_t p [NUM_EDGES];
		delta_t q [NUM_EDGES];
		if (en[0]) begin
			sx = delta_t'(seg.start_x);
			sy = delta_t'(seg.start_y);
			dx = delta_t'(seg.end_x) - sx;
			dy = delta_t'(seg.end_y) - sy;
			p[0] = -dx; q[0] = sx - delta_t'(left_q);
			p[1] = dx;  q[1] = delta_t'(right_q) - sx;
			p[2] = -dy; q[2] = sy - delta_t'(bottom_q);
			p[3] = dy;  q[3] = delta_t'(top_q) - sy;
			geo_s1 <= '{sx: seg.start_x, sy: seg.start_y, dx: dx, dy: dy};
			for (int l = 0; l < NUM_EDGES; l++) begin
				lane_s1[l] <= '{pzero: (p[l] == '0), pneg: p[l][C], qneg: q[l][C],
					neg: p[l][C] ^ q[l][C]};
				nm_s1[l] <= abs_mag(q[l]);
				dm_s1[l] <= abs_mag(p[l]);
			end
		end
	end

	// stage 2: rounded-division operands and saturation test
	geo_t          geo_s2;
	lane_t         lane_s2 [NUM_EDGES];
	logic [NW-1:0] rem_s2  [NUM_EDGES];
	logic [C:0]    dv_s2   [NUM_EDGES];
	logic          sat_s2  [NUM_EDGES];

	always_ff @(posedge clk) begin
		logic [NW-1:0] num, lim;
		logic [C:0]    dd;
		if (en[1]) begin
			geo_s2 <= geo_s1;
			for (int l = 0; l < NUM_EDGES; l++) begin
				dd  = {dm_s1[l], 1'b0};
				num = {1'b0, nm_s1[l], {FRAC_BITS{1'b0}}, 1'b0} + {{(NW-C){1'b0}}, dm_s1[l]};
				// quotients above one plus one lsb all act alike in the compares
				lim = {1'b0, dd, {FRAC_BITS{1'b0}}} + {{(NW-C-1){1'b0}}, dd};
				lane_s2[l] <= lane_s1[l];
				rem_s2[l]  <= num;
				dv_s2[l]   <= dd;
				sat_s2[l]  <= (num >= lim);
			end
		end
	end

	// restoring divider, one quotient bit per stage
	geo_t          geo_sd  [FRAC_BITS+1];
	lane_t         lane_sd [FRAC_BITS+1][NUM_EDGES];
	logic [NW-1:0] rem_sd  [FRAC_BITS+1][NUM_EDGES];
	logic [C:0]    dv_sd   [FRAC_BITS+1][NUM_EDGES];
	logic [QW-1:0] quo_sd  [FRAC_BITS+1][NUM_EDGES];
	logic          sat_sd  [FRAC_BITS+1][NUM_EDGES];

	for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_div
		localparam int K = FRAC_BITS - j;
		geo_t          geo_in;
		lane_t         lane_in [NUM_EDGES];
		logic [NW-1:0] rem_in  [NUM_EDGES];
		logic [C:0]    dv_in   [NUM_EDGES];
		logic [QW-1:0] quo_in  [NUM_EDGES];
		logic          sat_in  [NUM_EDGES];

		if (j == 0) begin : g_first
			assign geo_in = geo_s2;
			always_comb begin
				for (int l = 0; l < NUM_EDGES; l++) begin
					lane_in[l] = lane_s2[l];
					rem_in[l]  = rem_s2[l];
					dv_in[l]   = dv_s2[l];
					quo_in[l]  = '0;
					sat_in[l]  = sat_s2[l];
				end
			end
		end else begin : g_next
			assign geo_in = geo_sd[j-1];
			always_comb begin
				for (int l = 0; l < NUM_EDGES; l++) begin
					lane_in[l] = lane_sd[j-1][l];
					rem_in[l]  = rem_sd[j-1][l];
					dv_in[l]   = dv_sd[j-1][l];
					quo_in[l]  = quo_sd[j-1][l];
					sat_in[l]  = sat_sd[j-1][l];
				end
			end
		end

		always_ff @(posedge clk) begin
			logic [NW-1:0] sh;
			logic          ge;
			if (en[2+j]) begin
				geo_sd[j] <= geo_in;
				for (int l = 0; l < NUM_EDGES; l++) begin
					sh = {{(NW-C-1){1'b0}}, dv_in[l]} << K;
					ge = (rem_in[l] >= sh);
					lane_sd[j][l] <= lane_in[l];
					dv_sd[j][l]   <= dv_in[l];
					sat_sd[j][l]  <= sat_in[l];
					rem_sd[j][l]  <= ge ? rem_in[l] - sh : rem_in[l];
					quo_sd[j][l]  <= quo_in[l] | ({{(QW-1){1'b0}}, ge} << K);
				end
			end
		end
	end

	// stage 3: signed parameters, entry/exit reduction, reject test
	geo_t          geo_s3;
	logic [QW-1:0] u1_s3, u2_s3;
	logic          rej_s3;

	always_ff @(posedge clk) begin
		logic [QW:0]            qf;
		logic signed [TW-1:0]   tm, t, u1, u2;
		logic                   rej;
		if (en[ST3]) begin
			u1  = '0;
			u2  = U_ONE;
			rej = 1'b0;
			for (int l = 0; l < NUM_EDGES; l++) begin
				qf = sat_sd[FRAC_BITS][l] ? T_SAT : {1'b0, quo_sd[FRAC_BITS][l]};
				tm = $signed({1'b0, qf});
				t  = lane_sd[FRAC_BITS][l].neg ? -tm : tm;
				if (lane_sd[FRAC_BITS][l].pzero) begin
					if (lane_sd[FRAC_BITS][l].qneg) begin
						rej = 1'b1;
					end
				end else if (lane_sd[FRAC_BITS][l].pneg) begin
					if (t > u1) begin
						u1 = t;
					end
				end else if (t < u2) begin
					u2 = t;
				end
			end
			if (u1 > u2) begin
				rej = 1'b1;
			end
			geo_s3 <= geo_sd[FRAC_BITS];
			u1_s3  <= u1[QW-1:0];
			u2_s3  <= u2[QW-1:0];
			rej_s3 <= rej;
		end
	end

	// stage 4: u times direction
	coord_t               sx_s4, sy_s4;
	logic signed [PW-1:0] prod_s4 [NUM_EDGES];
	logic                 rej_s4;

	always_ff @(posedge clk) begin
		logic signed [QW:0] su1, su2;
		if (en[ST4]) begin
			su1 = $signed({1'b0, u1_s3});
			su2 = $signed({1'b0, u2_s3});
			sx_s4      <= geo_s3.sx;
			sy_s4      <= geo_s3.sy;
			rej_s4     <= rej_s3;
			prod_s4[0] <= su1 * geo_s3.dx;
			prod_s4[1] <= su1 * geo_s3.dy;
			prod_s4[2] <= su2 * geo_s3.dx;
			prod_s4[3] <= su2 * geo_s3.dy;
		end
	end

	// round half away from zero
	function automatic coord_t round_pt(input coord_t s, input logic signed [PW-1:0] pr);
		logic signed [PW-1:0] v;
		logic        [PW-1:0] a, r;
		coord_t               m;
		v = {{(PW-C-FRAC_BITS){s[C-1]}}, s, {FRAC_BITS{1'b0}}} + pr;
		a = v[PW-1] ? -v : v;
		r = (a + HALF) >> FRAC_BITS;
		m = r[C-1:0];
		return v[PW-1] ? -m : m;
	endfunction

	// stage 5: output register
	always_ff @(posedge clk) begin
		if (en[LAST]) begin
			if (rej_s4) begin
				clip <= '0;
			end else begin
				clip.visible         <= 1'b1;
				clip.clipped_start_x <= round_pt(sx_s4, prod_s4[0]);
				clip.clipped_start_y <= round_pt(sy_s4, prod_s4[1]);
				clip.clipped_end_x   <= round_pt(sx_s4, prod_s4[2]);
				clip.clipped_end_y   <= round_pt(sy_s4, prod_s4[3]);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/lcr_checker.sv @@
// port-level checks for the line clip rectangle top, bound to it
`default_nettype none
module lcr_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          seg_valid,
	input wire logic                          seg_ready,
	input wire logic                          clip_valid,
	input wire logic                          clip_ready,
	input wire lcr_pkg::clip_t                clip,
	input wire logic                          psel,
	input wire logic                          pready
);
	import lcr_pkg::*;

	// a held item stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		clip_valid && !clip_ready |=> clip_valid && $stable(clip))
		else $error("output item changed while stalled");

	// rejected segments carry zero coordinates
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		clip_valid && !clip.visible |-> clip.clipped_start_x == '0 &&
		clip.clipped_start_y == '0 && clip.clipped_end_x == '0 &&
		clip.clipped_end_y == '0)
		else $error("rejected item has nonzero coordinates");

	// an empty output stage never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!clip_valid |-> seg_ready)
		else $error("input stalled with empty output stage");

	// the config port never waits, even while items are flowing
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_ready && psel |-> pready)
		else $error("config port not ready");

endmodule

bind line_clip_rectangle_top lcr_checker u_lcr_checker (.*);
`default_nettype wire

@@ tb/tb_line_clip_rectangle_top.sv @@
// testbench for line_clip_rectangle_top: random and directed segments checked by a scoreboard
`timescale 1ns / 1ps
`default_nettype none
module tb_line_clip_rectangle_top;
	import lcr_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LATENCY = FRAC + 6;

	class clip_scoreboard;
		clip_t pending[$];
		longint win_l, win_b, win_r, win_t;
		int errors;

		function new();
			win_l = 0;
			win_b = 0;
			win_r = 639;
			win_t = 479;
			errors = 0;
		endfunction

		function longint round_div(longint num, longint den);
			bit neg;
			longint n, d;
			neg = (num < 0) != (den < 0);
			n = num < 0 ? -num : num;
			d = den < 0 ? -den : den;
			n = (2 * n + d) / (2 * d);
			return neg ? -n : n;
		endfunction

		function longint point_on(longint s, longint u, longint d);
			longint v;
			v = s * (longint'(1) << FRAC) + u * d;
			if (v >= 0)
				return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
			return -((-v + (longint'(1) << (FRAC - 1))) >>> FRAC);
		endfunction

		function clip_t clip_segment(seg_t s);
			clip_t r;
			longint sx, sy, dx, dy, u_in, u_out, t;
			longint p[4], q[4];
			bit rej;
			sx = s.start_x;
			sy = s.start_y;
			dx = longint'(s.end_x) - sx;
			dy = longint'(s.end_y) - sy;
			u_in = 0;
			u_out = longint'(1) << FRAC;
			rej = 0;
			p[0] = -dx; q[0] = sx - win_l;
			p[1] = dx;  q[1] = win_r - sx;
			p[2] = -dy; q[2] = sy - win_b;
			p[3] = dy;  q[3] = win_t - sy;
			for (int i = 0; i < 4; i++) begin
				if (p[i] == 0) begin
					if (q[i] < 0)
						rej = 1;
				end else begin
					t = round_div(q[i] * (longint'(1) << FRAC), p[i]);
					if (p[i] < 0) begin
						if (t > u_in)
							u_in = t;
					end else if (t < u_out) begin
						u_out = t;
					end
				end
			end
			if (u_in > u_out)
				rej = 1;
			r = '0;
			if (!rej) begin
				r.visible = 1'b1;
				r.clipped_start_x = coord_t'(point_on(sx, u_in, dx));
				r.clipped_start_y = coord_t'(point_on(sy, u_in, dy));
				r.clipped_end_x = coord_t'(point_on(sx, u_out, dx));
				r.clipped_end_y = coord_t'(point_on(sy, u_out, dy));
			end
			return r;
		endfunction

		function void note_segment(seg_t s);
			pending.push_back(clip_segment(s));
		endfunction

		function void check_clip(clip_t got);
			clip_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected clip result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.visible !== want.visible || got.clipped_start_x !== want.clipped_start_x
					|| got.clipped_start_y !== want.clipped_start_y
					|| got.clipped_end_x !== want.clipped_end_x
					|| got.clipped_end_y !== want.clipped_end_y) begin
				$display("%0t: clip mismatch expected %h actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic seg_valid = 0;
	logic seg_ready;
	seg_t seg = '0;
	logic clip_valid;
	logic clip_ready = 0;
	clip_t clip;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic pready;

	clip_scoreboard board = new();
	int send_idle = 0;
	int recv_stall = 0;
	logic hold_go = 0;
	logic hold_off = 0;

	line_clip_rectangle_top dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && clip_valid && clip_ready)
			board.check_clip(clip);
		if (hold_off) begin
			clip_ready <= 1'b0;
		end else begin
			clip_ready <= $urandom_range(99) >= recv_stall;
		end
	end

	// long receiver stall so the pipeline fills and blocks the input
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (200) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic write_window(reg_idx_t idx, coord_t v);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_BITS'(4 * int'(idx));
		pwdata <= DATA_BITS'(signed'(v));
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_LEFT: board.win_l = v;
			REG_BOTTOM: board.win_b = v;
			REG_RIGHT: board.win_r = v;
			default: board.win_t = v;
		endcase
		@(posedge clk);
	endtask

	task automatic set_window(coord_t l, coord_t b, coord_t r, coord_t t);
		write_window(REG_LEFT, l);
		write_window(REG_BOTTOM, b);
		write_window(REG_RIGHT, r);
		write_window(REG_TOP, t);
	endtask

	task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
		while ($urandom_range(99) < send_idle) begin
			seg_valid <= 0;
			@(posedge clk);
		end
		seg_valid <= 1;
		seg <= '{sx, sy, ex, ey};
		@(posedge clk);
		while (!seg_ready)
			@(posedge clk);
		board.note_segment('{sx, sy, ex, ey});
	endtask

	task automatic end_burst();
		seg_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic coord_t near_window(bit x_axis);
		longint lo, hi;
		lo = x_axis ? board.win_l : board.win_b;
		hi = x_axis ? board.win_r : board.win_t;
		if ($urandom_range(3) == 0)
			return coord_t'($urandom);
		if (lo > hi) begin
			lo = hi;
		end
		lo = lo - 100 < -2048 ? -2048 : lo - 100;
		hi = hi + 100 > 2047 ? 2047 : hi + 100;
		return coord_t'(lo + longint'($urandom_range(int'(hi - lo))));
	endfunction

	task automatic random_burst(int n);
		coord_t sx, sy;
		for (int i = 0; i < n; i++) begin
			sx = near_window(1);
			sy = near_window(0);
			case ($urandom_range(5))
				0: send_segment(sx, sy, sx, sy);
				1: send_segment(sx, sy, sx, near_window(0));
				2: send_segment(sx, sy, near_window(1), sy);
				default: send_segment(sx, sy, near_window(1), near_window(0));
			endcase
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, degenerate points, axis-parallel lines, crossings
		send_segment(-2048, -2048, 2047, 2047);
		send_segment(2047, 2047, -2048, -2048);
		send_segment(-2048, 2047, 2047, -2048);
		send_segment(100, 100, 100, 100);
		send_segment(0, 0, 0, 0);
		send_segment(639, 479, 639, 479);
		send_segment(640, 100, 640, 100);
		send_segment(-1, -1, -1, -1);
		send_segment(-100, 200, 800, 200);
		send_segment(300, -50, 300, 600);
		send_segment(-100, 500, 800, 500);
		send_segment(-500, -500, -10, -10);
		send_segment(10, 10, 600, 400);
		send_segment(-300, 240, 320, 900);
		send_segment(2047, -2048, -2048, 2047);
		send_segment(-2048, 0, -2048, 2047);
		send_segment(0, 2047, 2047, 2047);
		end_burst();
		set_window(-2048, -2048, 2047, 2047);
		send_segment(-2048, -2048, 2047, 2047);
		send_segment(2047, -2048, 2047, -2048);
		random_burst(60);
		end_burst();
		set_window(100, 50, -100, 300);
		send_segment(-200, 100, 200, 100);
		send_segment(0, 0, 0, 200);
		random_burst(40);
		end_burst();
		set_window(-5, -5, 5, 5);
		random_burst(100);
		end_burst();

		set_window(-300, -200, 300, 250);
		send_idle = 81;
		random_burst(120);
		send_idle = 0;
		recv_stall = 81;
		random_burst(120);
		send_idle = 32;
		recv_stall = 32;
		random_burst(120);
		end_burst();
		set_window(2047, 2047, 2047, 2047);
		random_burst(30);
		end_burst();
		set_window(0, 0, 639, 479);
		send_idle = 0;
		recv_stall = 0;
		hold_go <= 1'b1;
		random_burst(100);
		random_burst(40);
		end_burst();
		if (board.errors == 0)
			$display("tb_line_clip_rectangle_top passed");
		else
			$display("tb_line_clip_rectangle_top failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_line_clip_rectangle_top failed");
		$finish;
	end
endmodule
`default_nettype wire
